// File: design/ccds_pkg.sv
// Shared constants, codes and control structs for the charge current digipot stepper.
// Used by every module of the block; depends on nothing.
package ccds_pkg;

	// field widths
	localparam int MODE_W   = 2;
	localparam int MEAS_W   = 16;
	localparam int KIND_W   = 2;
	localparam int WIPER_W  = 6;
	localparam int CUR_W    = 11;
	localparam int CFG_IDX_W = 2;

	// input command codes
	localparam logic [MODE_W-1:0] MODE_ENABLE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DISABLE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_UP     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DOWN   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHARGE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 2'd1;

	localparam logic [CUR_W-1:0] CHARGE_RST = 11'd500;
	localparam logic [CUR_W-1:0] CUTOFF_RST = 11'd50;

	// wiper range and potentiometer
	localparam logic [WIPER_W-1:0] STEP_LOW   = 6'd0;
	localparam logic [WIPER_W-1:0] STEP_HIGH  = 6'd63;
	localparam logic [WIPER_W-1:0] START_STEP = 6'd32;
	localparam logic [WIPER_W-1:0] PULSE_MAX  = 6'd63;

	// serial divider sizes: dividend up to 1000000, divisor the charge current
	localparam int DIV_N_W = 20;
	localparam int DIV_D_W = 14;
	localparam int DIV_CNT_W = 5;
	localparam logic [DIV_N_W-1:0] RES_NUM   = 20'd1000000;
	localparam logic [DIV_D_W-1:0] POT_OHMS  = 14'd10000;
	localparam logic [DIV_N_W-1:0] STEP_SPAN = 20'(STEP_HIGH - STEP_LOW);

	// scaled resistance / pot value as a reciprocal multiply, exact below 2^20
	localparam int RECIP_SH = 33;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << RECIP_SH) + 64'(POT_OHMS) - 64'd1) / 64'(POT_OHMS);
	localparam logic [DIV_N_W-1:0] RECIP_M = RECIP_FULL[DIV_N_W-1:0];

	typedef struct packed {
		logic accept;     // take the input item
		logic div_start;  // launch the serial divider
		logic mul;        // scale the resistance onto the step range
		logic tgt;        // latch the target step
		logic pulse;      // move the wiper one step and issue a pulse item
		logic cutoff;     // apply the cutoff test
		logic status;     // issue the status item
	} ccds_cmd_t;

	typedef struct packed {
		logic div_done;
		logic charging;
		logic at_tgt;
		logic pulse_max;
		logic out_free;
	} ccds_sts_t;

endpackage

// File: design/ccds_div.sv
// Restoring divider, one quotient bit per cycle.
// Uses ccds_pkg for widths; instantiated by ccds_dpath.
module ccds_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ccds_pkg::DIV_N_W-1:0] dividend,
	input  logic [ccds_pkg::DIV_D_W-1:0] divisor,
	output logic [ccds_pkg::DIV_N_W-1:0] quotient,
	output logic                         done
);

	logic [ccds_pkg::DIV_N_W-1:0]   quo_q;
	logic [ccds_pkg::DIV_D_W-1:0]   rem_q;
	logic [ccds_pkg::DIV_D_W-1:0]   dsr_q;
	logic [ccds_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [ccds_pkg::DIV_D_W:0]     trial;
	logic                           fits;

	// a zero divisor always fits, so the quotient saturates to all ones
	assign trial = {rem_q, quo_q[ccds_pkg::DIV_N_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ccds_pkg::DIV_CNT_W'(ccds_pkg::DIV_N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[ccds_pkg::DIV_N_W-2:0], fits};
			rem_q <= fits ? ccds_pkg::DIV_D_W'(trial - {1'b0, dsr_q})
			              : trial[ccds_pkg::DIV_D_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// File: design/ccds_dpath.sv
// Datapath: configuration registers, wiper and charging state, target
// computation around the serial divider, and the output register.
// Depends on ccds_pkg and ccds_div.
module ccds_dpath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ccds_pkg::ccds_cmd_t              cmd,
	output ccds_pkg::ccds_sts_t              sts,
	input  logic                             cfg_we,
	input  logic [ccds_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ccds_pkg::CUR_W-1:0]       cfg_data,
	input  logic [ccds_pkg::MODE_W-1:0]      mode,
	input  logic [ccds_pkg::MEAS_W-1:0]      sense_current,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [ccds_pkg::KIND_W-1:0]      kind,
	output logic [ccds_pkg::WIPER_W-1:0]     wiper_position,
	output logic                             charging_on,
	output logic                             last
);

	logic [ccds_pkg::CUR_W-1:0]   charge_q;
	logic [ccds_pkg::CUR_W-1:0]   cutoff_q;
	logic [ccds_pkg::WIPER_W-1:0] wiper_q;
	logic                         charging_q;
	logic [ccds_pkg::MEAS_W-1:0]  meas_q;
	logic [ccds_pkg::DIV_N_W-1:0] prod_q;
	logic                         sat_q;
	logic [ccds_pkg::WIPER_W-1:0] tgt_q;
	logic [ccds_pkg::WIPER_W-1:0] n_q;
	logic                         out_valid_q;
	logic [ccds_pkg::KIND_W-1:0]  kind_q;
	logic [ccds_pkg::WIPER_W-1:0] wpos_q;
	logic                         chg_out_q;
	logic                         last_q;

	logic [ccds_pkg::DIV_N_W-1:0]   div_num;
	logic [ccds_pkg::DIV_D_W-1:0]   div_den;
	logic [ccds_pkg::DIV_N_W-1:0]   quo;
	logic                           div_done;
	logic [2*ccds_pkg::DIV_N_W-1:0] recip_prod;
	logic                           move_up;
	logic [ccds_pkg::WIPER_W-1:0]   wiper_next;
	logic                           below_cutoff;

	assign div_num = ccds_pkg::RES_NUM;
	assign div_den = ccds_pkg::DIV_D_W'(charge_q);

	ccds_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.quotient (quo),
		.done     (div_done)
	);

	assign recip_prod = {{ccds_pkg::DIV_N_W{1'b0}}, prod_q}
	                  * {{ccds_pkg::DIV_N_W{1'b0}}, ccds_pkg::RECIP_M};

	assign move_up      = wiper_q < tgt_q;
	assign wiper_next   = move_up ? wiper_q + 1'b1 : wiper_q - 1'b1;
	assign below_cutoff = {1'b0, cutoff_q, 4'b0000} > meas_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charge_q    <= ccds_pkg::CHARGE_RST;
			cutoff_q    <= ccds_pkg::CUTOFF_RST;
			wiper_q     <= ccds_pkg::START_STEP;
			charging_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == ccds_pkg::REG_CHARGE)
				charge_q <= cfg_data;
			if (cfg_we && cfg_index == ccds_pkg::REG_CUTOFF)
				cutoff_q <= cfg_data;
			if (cmd.accept) begin
				if (mode == ccds_pkg::MODE_ENABLE)
					charging_q <= 1'b1;
				else if (mode == ccds_pkg::MODE_DISABLE)
					charging_q <= 1'b0;
			end
			if (cmd.cutoff && below_cutoff)
				charging_q <= 1'b0;
			if (cmd.pulse)
				wiper_q <= wiper_next;
			if (cmd.pulse || cmd.status)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			meas_q <= sense_current;
			n_q    <= '0;
		end
		if (cmd.mul) begin
			sat_q  <= quo >= ccds_pkg::DIV_N_W'(ccds_pkg::POT_OHMS);
			prod_q <= ccds_pkg::DIV_N_W'(quo[ccds_pkg::DIV_D_W-1:0]) * ccds_pkg::STEP_SPAN;
		end
		// below the pot value the scaled step stays under the span
		if (cmd.tgt)
			tgt_q <= sat_q ? ccds_pkg::STEP_HIGH
			               : recip_prod[ccds_pkg::RECIP_SH +: ccds_pkg::WIPER_W]
			                 + ccds_pkg::STEP_LOW;
		if (cmd.pulse) begin
			n_q       <= n_q + 1'b1;
			kind_q    <= move_up ? ccds_pkg::KIND_UP : ccds_pkg::KIND_DOWN;
			wpos_q    <= wiper_next;
			chg_out_q <= charging_q;
			last_q    <= 1'b0;
		end else if (cmd.status) begin
			kind_q    <= ccds_pkg::KIND_STATUS;
			wpos_q    <= wiper_q;
			chg_out_q <= charging_q;
			last_q    <= 1'b1;
		end
	end

	assign sts.div_done  = div_done;
	assign sts.charging  = charging_q;
	assign sts.at_tgt    = wiper_q == tgt_q;
	assign sts.pulse_max = n_q == ccds_pkg::PULSE_MAX;
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign wiper_position = wpos_q;
	assign charging_on    = chg_out_q;
	assign last           = last_q;

endmodule

// File: design/ccds_ctrl.sv
// Controller: sequences command handling, the resistance division and the wiper pulses.
// Depends on ccds_pkg; drives ccds_dpath through ccds_cmd_t.
module ccds_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ccds_pkg::MODE_W-1:0] mode,
	input  ccds_pkg::ccds_sts_t         sts,
	output ccds_pkg::ccds_cmd_t         cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_D1GO = 4'd1;
	localparam logic [3:0] S_D1W  = 4'd2;
	localparam logic [3:0] S_MUL  = 4'd3;
	localparam logic [3:0] S_TGT  = 4'd4;
	localparam logic [3:0] S_STEP = 4'd5;
	localparam logic [3:0] S_STAT = 4'd6;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_stall = state_q != S_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (mode == ccds_pkg::MODE_COMPUTE && sts.charging)
						state_d = S_D1GO;
					else
						state_d = S_STAT;
				end
			end
			S_D1GO: begin
				cmd.div_start = 1'b1;
				state_d       = S_D1W;
			end
			S_D1W: begin
				if (sts.div_done)
					state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_TGT;
			end
			S_TGT: begin
				cmd.tgt = 1'b1;
				state_d = S_STEP;
			end
			S_STEP: begin
				// cut off only once the wiper has stopped moving
				if (sts.at_tgt || sts.pulse_max) begin
					cmd.cutoff = 1'b1;
					state_d    = S_STAT;
				end else if (sts.out_free) begin
					cmd.pulse = 1'b1;
				end
			end
			S_STAT: begin
				if (sts.out_free) begin
					cmd.status = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// File: design/charge_current_digipot_stepper_core.sv
// Enable, disable, unused commands and a compute while not charging go straight from
// acceptance to their status item. A compute while charging runs one pass of the serial
// divider and the target scaling, then issues one wiper pulse at a time, up to 63 pulses;
// pulses and the status item wait while the output is stalled.
// One item is worked on at a time; the next is taken once the status item is issued.
// Reset (arst_n low, asynchronous) sets wiper 32, charging off, charge 500 mA, cutoff 50 mA.
module charge_current_digipot_stepper_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ccds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ccds_pkg::CUR_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [ccds_pkg::MODE_W-1:0]    mode,
	input  logic [ccds_pkg::MEAS_W-1:0]    sense_current,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ccds_pkg::KIND_W-1:0]    kind,
	output logic [ccds_pkg::WIPER_W-1:0]   wiper_position,
	output logic                           charging_on,
	output logic                           last
);

	ccds_pkg::ccds_cmd_t cmd;
	ccds_pkg::ccds_sts_t sts;

	ccds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.sts      (sts),
		.cmd      (cmd)
	);

	ccds_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mode           (mode),
		.sense_current  (sense_current),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.wiper_position (wiper_position),
		.charging_on    (charging_on),
		.last           (last)
	);

endmodule
